>>> rtl/lsfs_pkg.sv
// Types and constants shared by the latching solenoid flush sequencer.
package lsfs_pkg;

    typedef enum logic [3:0] {
        PH_STARTUP = 4'd0,
        PH_IDLE    = 4'd1,
        PH_DELAY   = 4'd2,
        PH_FORWARD = 4'd3,
        PH_BRAKE   = 4'd4,
        PH_REVERSE = 4'd5,
        PH_HOLD    = 4'd6,
        PH_END     = 4'd7,
        PH_RELEASE = 4'd8
    } t_phase;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_STARTUP_WAIT  = 4'd0;
    localparam t_cfg_idx CFG_INITIAL_DELAY = 4'd1;
    localparam t_cfg_idx CFG_COIL_PULSE    = 4'd2;
    localparam t_cfg_idx CFG_MIN_FLUSH     = 4'd3;
    localparam t_cfg_idx CFG_FLUSH_STEP    = 4'd4;
    localparam t_cfg_idx CFG_BRAKE_HOLD    = 4'd5;
    localparam t_cfg_idx CFG_END_DELAY     = 4'd6;
    localparam t_cfg_idx CFG_HYSTERESIS    = 4'd7;

    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_STARTUP_WAIT  = 16'd3000;
    localparam logic [15:0] RST_INITIAL_DELAY = 16'd290;
    localparam logic [15:0] RST_COIL_PULSE    = 16'd15;
    localparam logic [14:0] RST_MIN_FLUSH     = 15'd1650;
    localparam logic [8:0]  RST_FLUSH_STEP    = 9'd100;
    localparam logic [15:0] RST_BRAKE_HOLD    = 16'd100;
    localparam logic [15:0] RST_END_DELAY     = 16'd1900;
    localparam logic [3:0]  RST_HYSTERESIS    = 4'd3;

    // Potentiometer clamp, applied to the halved sample
    localparam logic [6:0] POT_CLAMP_LO = 7'd8;
    localparam logic [6:0] POT_CLAMP_HI = 7'd119;

endpackage

>>> rtl/latching_solenoid_flush_sequencer.sv
// Top level of the latching solenoid flush sequencer: filter, phase sequencer, output register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_button_level, i_pot_sample
//  out     | output    | o_out_valid/i_out_ready| o_drive_in1, o_drive_in2, o_button_state,
//          |           |                        | o_phase
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One request per cycle while the result is not stalled: each request is worked out in the
//  cycle it is accepted and its result is loaded into the output register on the next edge.
//  The output register is the only stage; a new request is taken whenever that register is
//  empty or is being drained in the same cycle, so a stalled result stalls the input.
//  Reset (synchronous, active low) empties the output register, restores the registers to
//  their defaults and puts the sequencer in the startup phase with clear history.
//  Configuration writes are taken every cycle; indexes past the list are dropped.
module latching_solenoid_flush_sequencer #(
    parameter int unsigned HISTORY_LEN = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input requests
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_button_level,
    input  logic [7:0]                  i_pot_sample,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_drive_in1,
    output logic                        o_drive_in2,
    output logic                        o_button_state,
    output lsfs_pkg::t_phase            o_phase,
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  lsfs_pkg::t_cfg_idx          i_cfg_index,
    input  logic [lsfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsfs_pkg::*;

    // Popcount width, and a compare width that also holds count plus margin
    localparam int unsigned CNT_W = $clog2(HISTORY_LEN + 1);
    localparam int unsigned TH_W  = $clog2(HISTORY_LEN + 16 + 1);
    localparam logic [TH_W-1:0] HALF_T = TH_W'(HISTORY_LEN / 2);

    // Configuration registers
    logic [15:0] r_startup_wait;
    logic [15:0] r_initial_delay;
    logic [15:0] r_coil_pulse;
    logic [14:0] r_min_flush;
    logic [8:0]  r_flush_step;
    logic [15:0] r_brake_hold;
    logic [15:0] r_end_delay;
    logic [3:0]  r_hysteresis;

    // Sequencer state
    logic [HISTORY_LEN-1:0] r_history, n_history;
    logic                   r_filtered, n_filtered;
    t_phase                 r_phase, n_phase;
    logic [15:0]            r_tick, n_tick;
    logic [15:0]            r_flush, n_flush;

    // Output register
    logic r_out_valid;

    logic w_in_accept;
    logic w_cfg_accept;

    // Filter path
    logic [HISTORY_LEN-1:0] w_hist_shift;
    logic [CNT_W-1:0]       w_count;
    logic [TH_W-1:0]        w_count_t;
    logic [TH_W-1:0]        w_margin_t;
    logic                   w_filt_new;

    // Flush time path
    logic [6:0]  w_pot_half;
    logic [6:0]  w_pot_clamped;
    logic [6:0]  w_pot_steps;
    logic [15:0] w_flush_prod;
    logic [16:0] w_flush_sum;
    logic [15:0] w_flush_new;

    logic [15:0] w_tick_inc;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_accept = i_cfg_valid;
    assign o_out_valid  = r_out_valid;

    // Duration of a timed phase; the flush time is passed in so a fresh latch can be used
    function automatic logic [15:0] phase_len(input t_phase p, input logic [15:0] flush);
        logic [15:0] len;
        case (p)
            PH_DELAY:   len = r_initial_delay;
            PH_FORWARD: len = r_coil_pulse;
            PH_BRAKE:   len = flush;
            PH_REVERSE: len = r_coil_pulse;
            PH_HOLD:    len = r_brake_hold;
            PH_END:     len = r_end_delay;
            default:    len = 16'd1;
        endcase
        return len;
    endfunction

    // Enter a phase, stepping over timed phases of zero length; past the end coast
    // this lands on wait-release.
    function automatic t_phase skip_empty(input t_phase p, input logic [15:0] flush);
        t_phase ph;
        ph = p;
        for (int i = int'(PH_DELAY); i <= int'(PH_END); i++) begin
            if (ph == t_phase'(4'(i)) && phase_len(ph, flush) == 16'd0) begin
                ph = t_phase'(4'(ph) + 4'd1);
            end
        end
        return ph;
    endfunction

    // Button filter: shift in the pressed bit, count, compare with hysteresis
    always_comb begin
        w_hist_shift = {r_history[HISTORY_LEN-2:0], ~i_button_level};
        w_count = '0;
        for (int i = 0; i < HISTORY_LEN; i++) begin
            w_count = w_count + CNT_W'(w_hist_shift[i]);
        end
        w_count_t  = TH_W'(w_count);
        w_margin_t = TH_W'(r_hysteresis);
        // release at count <= half - margin, press at count >= half + margin;
        // written without subtraction so a margin above half simply never fires
        if (r_filtered && (w_count_t + w_margin_t <= HALF_T)) begin
            w_filt_new = 1'b0;
        end else if (!r_filtered && (w_count_t >= HALF_T + w_margin_t)) begin
            w_filt_new = 1'b1;
        end else begin
            w_filt_new = r_filtered;
        end
    end

    // Flush time: halve the sample, clamp, scale by the step, add the minimum, saturate
    always_comb begin
        w_pot_half = i_pot_sample[7:1];
        if (w_pot_half < POT_CLAMP_LO) begin
            w_pot_clamped = POT_CLAMP_LO;
        end else if (w_pot_half > POT_CLAMP_HI) begin
            w_pot_clamped = POT_CLAMP_HI;
        end else begin
            w_pot_clamped = w_pot_half;
        end
        w_pot_steps  = w_pot_clamped - POT_CLAMP_LO;
        w_flush_prod = 16'(w_pot_steps) * 16'(r_flush_step);
        w_flush_sum  = 17'(w_flush_prod) + 17'(r_min_flush);
        w_flush_new  = w_flush_sum[16] ? 16'hFFFF : w_flush_sum[15:0];
    end

    // Saturating tick increment
    assign w_tick_inc = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;

    // Next state of the sequencer for the request being accepted
    always_comb begin
        n_history  = r_history;
        n_filtered = r_filtered;
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_flush    = r_flush;
        case (r_phase)
            PH_STARTUP: begin
                // button is ignored until the startup wait has run out
                if (w_tick_inc >= r_startup_wait) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end else begin
                    n_tick  = w_tick_inc;
                end
            end
            PH_IDLE: begin
                n_history  = w_hist_shift;
                n_filtered = w_filt_new;
                if (w_filt_new) begin
                    // latch the flush time and start the sequence on this same tick
                    n_flush = w_flush_new;
                    n_phase = skip_empty(PH_DELAY, w_flush_new);
                    n_tick  = '0;
                end
            end
            PH_DELAY, PH_FORWARD, PH_BRAKE, PH_REVERSE, PH_HOLD, PH_END: begin
                // filter is frozen; advance once the phase length is reached
                if (w_tick_inc >= phase_len(r_phase, r_flush)) begin
                    n_phase = skip_empty(t_phase'(4'(r_phase) + 4'd1), r_flush);
                    n_tick  = '0;
                end else begin
                    n_tick  = w_tick_inc;
                end
            end
            PH_RELEASE: begin
                n_history  = w_hist_shift;
                n_filtered = w_filt_new;
                if (!w_filt_new) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_wait  <= RST_STARTUP_WAIT;
            r_initial_delay <= RST_INITIAL_DELAY;
            r_coil_pulse    <= RST_COIL_PULSE;
            r_min_flush     <= RST_MIN_FLUSH;
            r_flush_step    <= RST_FLUSH_STEP;
            r_brake_hold    <= RST_BRAKE_HOLD;
            r_end_delay     <= RST_END_DELAY;
            r_hysteresis    <= RST_HYSTERESIS;
        end else if (w_cfg_accept) begin
            case (i_cfg_index)
                CFG_STARTUP_WAIT:  r_startup_wait  <= i_cfg_data;
                CFG_INITIAL_DELAY: r_initial_delay <= i_cfg_data;
                CFG_COIL_PULSE:    r_coil_pulse    <= i_cfg_data;
                CFG_MIN_FLUSH:     r_min_flush     <= i_cfg_data[14:0];
                CFG_FLUSH_STEP:    r_flush_step    <= i_cfg_data[8:0];
                CFG_BRAKE_HOLD:    r_brake_hold    <= i_cfg_data;
                CFG_END_DELAY:     r_end_delay     <= i_cfg_data;
                CFG_HYSTERESIS:    r_hysteresis    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history  <= '0;
            r_filtered <= 1'b0;
            r_phase    <= PH_STARTUP;
            r_tick     <= '0;
            r_flush    <= '0;
        end else if (w_in_accept) begin
            r_history  <= n_history;
            r_filtered <= n_filtered;
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_flush    <= n_flush;
        end
    end

    // Output register: hold until drained, load on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            o_drive_in1    <= (n_phase == PH_FORWARD) || (n_phase == PH_BRAKE)
                              || (n_phase == PH_HOLD);
            o_drive_in2    <= (n_phase == PH_BRAKE) || (n_phase == PH_REVERSE)
                              || (n_phase == PH_HOLD);
            o_button_state <= n_filtered;
            o_phase        <= n_phase;
        end
    end

`ifndef SYNTHESIS
    // Brake drive only ever appears in the brake and brake-hold phases
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_in1 && o_drive_in2) |->
            (o_phase == PH_BRAKE || o_phase == PH_HOLD))
        else $error("brake drive outside a brake phase");

    // The filter does not move while a flush sequence runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_phase >= PH_DELAY && r_phase <= PH_END) |=>
            ($stable(r_history) && $stable(r_filtered)))
        else $error("button filter changed during flush");

    // Every phase change starts with a cleared tick counter
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && n_phase != r_phase) |=> (r_tick == 16'd0))
        else $error("tick counter not cleared on phase change");

    // A stalled result blocks new requests
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result is stalled");

    // Reset puts the sequencer into startup with an empty output register
    assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_STARTUP && !o_out_valid))
        else $error("reset did not restore startup phase");
`endif

endmodule
